// ----- rtl/pressure_sensor_compensation_unit_macros.svh -----
// Assertion macros shared by the pressure compensation RTL.
`ifndef PRESSURE_SENSOR_COMPENSATION_UNIT_MACROS_SVH
`define PRESSURE_SENSOR_COMPENSATION_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define PSCU_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pscu: property failed");
`define PSCU_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("pscu: forbidden condition seen");
`else
`define PSCU_ASSERT(label, clk, rst, prop)
`define PSCU_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

// ----- rtl/psc_pkg.sv -----
// Shared types and constants for the pressure compensation unit.
`timescale 1ns / 1ps
package psc_pkg;

   localparam int unsigned CoefWidth  = 16;
   localparam int unsigned CountWidth = 10;
   localparam int unsigned CentiWidth = 14;
   localparam int unsigned CsrIdxWidth = 3;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_A0  = 3'd0,
      CSR_B1  = 3'd1,
      CSR_B2  = 3'd2,
      CSR_C12 = 3'd3,
      CSR_C11 = 3'd4,
      CSR_C22 = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [CoefWidth-1:0] a0;
      logic signed [CoefWidth-1:0] b1;
      logic signed [CoefWidth-1:0] b2;
      logic signed [CoefWidth-1:0] c12;
      logic signed [CoefWidth-1:0] c11;
      logic signed [CoefWidth-1:0] c22;
   } coef_type;

   typedef struct packed {
      logic [CountWidth-1:0] count;
      logic                  oor;
   } meas_type;

   localparam logic [12:0]           CentiSpan  = 13'd6500;
   localparam logic [CentiWidth-1:0] CentiBase  = 14'd5000;
   localparam logic [CountWidth-1:0] CountMax   = 10'd1023;

endpackage

// ----- rtl/psc_csr.sv -----
// Coefficient register file with a plain write port.
`timescale 1ns / 1ps
module psc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [psc_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [psc_pkg::CoefWidth-1:0]        csr_write_data,
   output psc_pkg::coef_type                    coef
);

   psc_pkg::coef_type coef_ff;
   psc_pkg::coef_type coef_in;

   always_comb begin
      coef_in = coef_ff;
      if (csr_write_enable) begin
         unique case (psc_pkg::csr_index_type'(csr_index))
            psc_pkg::CSR_A0:  coef_in.a0  = csr_write_data;
            psc_pkg::CSR_B1:  coef_in.b1  = csr_write_data;
            psc_pkg::CSR_B2:  coef_in.b2  = csr_write_data;
            psc_pkg::CSR_C12: coef_in.c12 = csr_write_data;
            psc_pkg::CSR_C11: coef_in.c11 = csr_write_data;
            psc_pkg::CSR_C22: coef_in.c22 = csr_write_data;
            default:          coef_in     = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '0;
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ----- rtl/psc_poly.sv -----
// Six-stage pipeline that evaluates the compensation polynomial and saturates.
`timescale 1ns / 1ps
`include "pressure_sensor_compensation_unit_macros.svh"
module psc_poly (
   input  logic                            clock,
   input  logic                            reset,
   input  psc_pkg::coef_type               coef,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [psc_pkg::CountWidth-1:0]  in_padc,
   input  logic [psc_pkg::CountWidth-1:0]  in_tadc,
   output logic                            out_valid,
   input  logic                            out_ready,
   output psc_pkg::meas_type               out_meas
);

   localparam int unsigned Stages = 6;

   logic [Stages-1:0] vld_ff;
   logic [Stages:0]   adv;

   // stage 1: first products
   logic [9:0]         padc1_ff, tadc1_ff;
   logic signed [26:0] p11_ff, p12_ff, p22_ff;
   logic signed [26:0] p11_in, p12_in, p22_in;
   // stage 2: a11, a2
   logic [9:0]         padc2_ff, tadc2_ff;
   logic signed [26:0] p12b_ff;
   logic [16:0]        a11_ff, a11_in;
   logic [15:0]        a2_ff, a2_in;
   logic [30:0]        s11;
   logic [31:0]        s22;
   // stage 3: a1, a2*tadc
   logic [9:0]         padc3_ff;
   logic [17:0]        a1_ff, a1_in;
   logic [28:0]        s1;
   logic signed [26:0] a2t_ff, a2t_in;
   // stage 4: a1*padc
   logic signed [28:0] a1p_ff, a1p_in;
   logic signed [26:0] a2t4_ff;
   // stage 5: y1
   logic [19:0]        y1_ff, y1_in;
   logic [29:0]        sy;
   logic signed [26:0] a2t5_ff;
   // stage 6: saturation
   logic [30:0]        sm;
   psc_pkg::meas_type  meas_ff, meas_in;

   always_comb begin
      adv[Stages] = out_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[Stages-1];
   assign out_meas  = meas_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < Stages; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   always_comb begin
      p11_in = 27'(coef.c11) * 27'($signed({1'b0, in_padc}));
      p12_in = 27'(coef.c12) * 27'($signed({1'b0, in_tadc}));
      p22_in = 27'(coef.c22) * 27'($signed({1'b0, in_tadc}));

      s11   = {coef.b1[15], coef.b1, 14'b0} + {{4{p11_ff[26]}}, p11_ff};
      a11_in = s11[30:14];
      s22   = {coef.b2[15], coef.b2, 15'b0} + {{6{p22_ff[26]}}, p22_ff[26:1]};
      a2_in  = s22[31:16];

      s1     = {a11_ff[16], a11_ff, 11'b0} + {{2{p12b_ff[26]}}, p12b_ff};
      a1_in  = s1[28:11];
      a2t_in = 27'($signed(a2_ff)) * 27'($signed({1'b0, tadc2_ff}));

      a1p_in = 29'($signed(a1_ff)) * 29'($signed({1'b0, padc3_ff}));

      sy    = {{4{coef.a0[15]}}, coef.a0, 10'b0} + {a1p_ff[28], a1p_ff};
      y1_in = sy[29:10];

      sm = {y1_ff[19], y1_ff, 10'b0} + {{4{a2t5_ff[26]}}, a2t5_ff};
      // truncation toward zero: small negatives land on zero in range
      if (sm[30]) begin
         meas_in.count = '0;
         meas_in.oor   = ~(&sm[30:13] & |sm[12:0]);
      end else if (|sm[29:23]) begin
         meas_in.count = psc_pkg::CountMax;
         meas_in.oor   = 1'b1;
      end else begin
         meas_in.count = sm[22:13];
         meas_in.oor   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         padc1_ff <= in_padc;
         tadc1_ff <= in_tadc;
         p11_ff   <= p11_in;
         p12_ff   <= p12_in;
         p22_ff   <= p22_in;
      end
      if (adv[1]) begin
         padc2_ff <= padc1_ff;
         tadc2_ff <= tadc1_ff;
         p12b_ff  <= p12_ff;
         a11_ff   <= a11_in;
         a2_ff    <= a2_in;
      end
      if (adv[2]) begin
         padc3_ff <= padc2_ff;
         a1_ff    <= a1_in;
         a2t_ff   <= a2t_in;
      end
      if (adv[3]) begin
         a1p_ff  <= a1p_in;
         a2t4_ff <= a2t_ff;
      end
      if (adv[4]) begin
         y1_ff   <= y1_in;
         a2t5_ff <= a2t4_ff;
      end
      if (adv[5]) begin
         meas_ff <= meas_in;
      end
   end

   `PSCU_ASSERT(a_sat_rails, clock, reset, out_valid && out_meas.oor |->
      (out_meas.count == '0 || out_meas.count == psc_pkg::CountMax))
   `PSCU_ASSERT_NEVER(a_empty_blocks, clock, reset, !out_valid && !in_ready)

endmodule

// ----- rtl/psc_scale.sv -----
// Three-stage pipeline converting the count to hundredths of kPa.
`timescale 1ns / 1ps
module psc_scale (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  psc_pkg::meas_type               in_meas,
   output logic                            out_valid,
   input  logic                            out_ready,
   output psc_pkg::meas_type               out_meas,
   output logic [psc_pkg::CentiWidth-1:0]  out_centi
);

   localparam int unsigned Stages = 3;

   logic [Stages-1:0] vld_ff;
   logic [Stages:0]   adv;

   psc_pkg::meas_type meas1_ff, meas2_ff, meas3_ff;
   logic [22:0] x1_ff, x1_in;
   logic [22:0] x2_ff;
   logic [33:0] xr;
   logic [12:0] q_ff, q_in;
   logic [23:0] rem;
   logic [12:0] qc;
   logic [psc_pkg::CentiWidth-1:0] centi_ff, centi_in;

   always_comb begin
      adv[Stages] = out_ready;
      for (int k = Stages - 1; k >= 0; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = vld_ff[Stages-1];
   assign out_meas  = meas3_ff;
   assign out_centi = centi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < Stages; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= (k == 0) ? in_valid : vld_ff[(k == 0) ? 0 : k - 1];
            end
         end
      end
   end

   // x/1023 estimated as x*1025 >> 20 (never high, at most one low), then fixed up
   always_comb begin
      x1_in    = 23'(psc_pkg::CentiSpan) * 23'(in_meas.count);
      xr       = {11'b0, x1_ff} + {1'b0, x1_ff, 10'b0};
      q_in     = xr[32:20];
      rem      = {1'b0, x2_ff} + {11'b0, q_ff} - {1'b0, q_ff, 10'b0};
      qc       = q_ff + 13'((rem >= 24'd1023) ? 1 : 0);
      centi_in = psc_pkg::CentiBase + {1'b0, qc};
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         meas1_ff <= in_meas;
         x1_ff    <= x1_in;
      end
      if (adv[1]) begin
         meas2_ff <= meas1_ff;
         x2_ff    <= x1_ff;
         q_ff     <= q_in;
      end
      if (adv[2]) begin
         meas3_ff <= meas2_ff;
         centi_ff <= centi_in;
      end
   end

endmodule

// ----- rtl/pressure_sensor_compensation_unit.sv -----
// Top level of the barometric pressure polynomial compensation unit.
// Throughput: one item per cycle unless rsp_ready stalls it, set by the nine-stage pipeline
// (six polynomial stages, three scaling stages).
// A stalled output holds its item; empty stages keep taking new items.
// Synchronous reset empties the pipeline and clears all coefficients to 0.
`timescale 1ns / 1ps
`include "pressure_sensor_compensation_unit_macros.svh"
module pressure_sensor_compensation_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [15:0]                          req_pressure_raw,
   input  logic [15:0]                          req_temp_raw,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [psc_pkg::CountWidth-1:0]       rsp_pcomp,
   output logic [psc_pkg::CentiWidth-1:0]       rsp_pressure_centi_kpa,
   output logic                                 rsp_out_of_range,
   input  logic                                 csr_write_enable,
   input  logic [psc_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [psc_pkg::CoefWidth-1:0]        csr_write_data
);

   psc_pkg::coef_type coef;
   psc_pkg::meas_type poly_meas;
   psc_pkg::meas_type rsp_meas;
   logic              poly_valid;
   logic              poly_ready;

   psc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .coef             (coef)
   );

   psc_poly u_poly (
      .clock     (clock),
      .reset     (reset),
      .coef      (coef),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_padc   (req_pressure_raw[15:6]),
      .in_tadc   (req_temp_raw[15:6]),
      .out_valid (poly_valid),
      .out_ready (poly_ready),
      .out_meas  (poly_meas)
   );

   psc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (poly_valid),
      .in_ready  (poly_ready),
      .in_meas   (poly_meas),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_meas  (rsp_meas),
      .out_centi (rsp_pressure_centi_kpa)
   );

   assign rsp_pcomp        = rsp_meas.count;
   assign rsp_out_of_range = rsp_meas.oor;

   `PSCU_ASSERT(a_centi_range, clock, reset, rsp_valid |-> (rsp_pressure_centi_kpa >= 14'd5000 && rsp_pressure_centi_kpa <= 14'd11500))
   `PSCU_ASSERT(a_centi_ends, clock, reset, rsp_valid && (rsp_pcomp == '0 || rsp_pcomp == psc_pkg::CountMax) |-> (rsp_pressure_centi_kpa == 14'd5000 || rsp_pressure_centi_kpa == 14'd11500))

endmodule

// ----- sim/psc_checker.sv -----
// Checker for the pressure compensation unit: predicts each reading and compares it.
`timescale 1ns / 1ps
module psc_checker
   import psc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_ready,
   input  logic [15:0]            req_pressure_raw,
   input  logic [15:0]            req_temp_raw,
   input  logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  logic [CountWidth-1:0]  rsp_pcomp,
   input  logic [CentiWidth-1:0]  rsp_pressure_centi_kpa,
   input  logic                   rsp_out_of_range,
   input  logic                   csr_write_enable,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CoefWidth-1:0]   csr_write_data,
   output int                     pending,
   output int                     fail_count
);

   typedef struct packed {
      logic [CountWidth-1:0] pcomp;
      logic [CentiWidth-1:0] centi;
      logic                  oor;
   } reading_type;

   coef_type    coefs;
   reading_type expected_readings[$];
   int          errors = 0;

   function automatic reading_type compensate(input coef_type c, input logic [15:0] praw,
                                              input logic [15:0] traw);
      longint      padc;
      longint      tadc;
      longint      a11;
      longint      a1;
      longint      a2;
      longint      y1;
      longint      raw;
      reading_type r;
      padc = longint'(praw[15:6]);
      tadc = longint'(traw[15:6]);
      a11 = (longint'($signed(c.b1)) * 16384 + longint'($signed(c.c11)) * padc) >>> 14;
      a1  = (a11 * 2048 + longint'($signed(c.c12)) * tadc) >>> 11;
      a2  = (longint'($signed(c.b2)) * 32768
             + ((longint'($signed(c.c22)) * tadc) >>> 1)) >>> 16;
      y1  = (longint'($signed(c.a0)) * 1024 + a1 * padc) >>> 10;
      raw = (y1 * 1024 + a2 * tadc) / 8192;
      if (raw < 0) begin
         r.pcomp = '0;
         r.oor   = 1'b1;
      end else if (raw > 1023) begin
         r.pcomp = CountMax;
         r.oor   = 1'b1;
      end else begin
         r.pcomp = raw[CountWidth-1:0];
         r.oor   = 1'b0;
      end
      r.centi = CentiWidth'(5000 + (6500 * longint'(r.pcomp)) / 1023);
      return r;
   endfunction

   always @(posedge clock) begin
      reading_type want;
      if (reset) begin
         expected_readings.delete();
         coefs <= '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               if (errors < 10)
                  $display("%0t: unexpected item pcomp=%0d centi=%0d oor=%0d", $realtime,
                           rsp_pcomp, rsp_pressure_centi_kpa, rsp_out_of_range);
               errors++;
            end else begin
               want = expected_readings.pop_front();
               if (rsp_pcomp !== want.pcomp || rsp_pressure_centi_kpa !== want.centi ||
                   rsp_out_of_range !== want.oor) begin
                  if (errors < 10)
                     $display("%0t: mismatch exp pcomp=%0d centi=%0d oor=%0d got %0d %0d %0d",
                              $realtime, want.pcomp, want.centi, want.oor, rsp_pcomp,
                              rsp_pressure_centi_kpa, rsp_out_of_range);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_readings.push_back(compensate(coefs, req_pressure_raw, req_temp_raw));
         if (csr_write_enable) begin
            case (csr_index_type'(csr_index))
               CSR_A0:  coefs.a0  <= csr_write_data;
               CSR_B1:  coefs.b1  <= csr_write_data;
               CSR_B2:  coefs.b2  <= csr_write_data;
               CSR_C12: coefs.c12 <= csr_write_data;
               CSR_C11: coefs.c11 <= csr_write_data;
               CSR_C22: coefs.c22 <= csr_write_data;
               default: ;
            endcase
         end
      end
      pending    <= expected_readings.size();
      fail_count <= errors;
   end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the pressure compensation unit: stimulus, coefficient loads and verdict.
`timescale 1ns / 1ps
module tb_top;
   import psc_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [15:0]            req_pressure_raw;
   logic [15:0]            req_temp_raw;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [CountWidth-1:0]  rsp_pcomp;
   logic [CentiWidth-1:0]  rsp_pressure_centi_kpa;
   logic                   rsp_out_of_range;
   logic                   csr_write_enable;
   logic [CsrIdxWidth-1:0] csr_index;
   logic [CoefWidth-1:0]   csr_write_data;
   int                     pending;
   int                     fail_count;

   int idle_pct  = 0;
   int stall_pct = 0;
   bit hold_go   = 1'b0;

   localparam coef_type TypicalCoefs = '{a0: 16'sd16078, b1: -16'sd19463, b2: -16'sd15081,
                                         c12: 16'sd13256, c11: 16'sd0, c22: 16'sd0};

   pressure_sensor_compensation_unit DUT (.*);
   psc_checker checker_i (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Verification failed");
      $finish;
   end

   // receiver: random stalls, plus one long hold-off when requested
   initial begin
      int held;
      held = 0;
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && held < 300) begin
            rsp_ready <= 1'b0;
            held++;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   task automatic send_item(input logic [15:0] p, input logic [15:0] t);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_pressure_raw <= p;
      req_temp_raw     <= t;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   task automatic load_coefs(input coef_type c);
      logic [CoefWidth-1:0] vals [6];
      vals[CSR_A0]  = c.a0;
      vals[CSR_B1]  = c.b1;
      vals[CSR_B2]  = c.b2;
      vals[CSR_C12] = c.c12;
      vals[CSR_C11] = c.c11;
      vals[CSR_C22] = c.c22;
      // indexes past the last register get junk that must be ignored
      for (int k = 0; k < (1 << CsrIdxWidth); k++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CsrIdxWidth'(k);
         csr_write_data   <= (k <= CSR_C22) ? vals[k] : CoefWidth'($urandom_range(0, 65535));
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      coef_type cs;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_pressure_raw <= '0;
      req_temp_raw     <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // coefficients at reset value
      send_item(16'h1234, 16'h4321);
      drain();

      load_coefs(TypicalCoefs);
      send_item(16'h0000, 16'h0000);
      send_item(16'hFFFF, 16'hFFFF);
      send_item(16'h0000, 16'hFFFF);
      send_item(16'hFFFF, 16'h0000);
      send_item(16'h003F, 16'h003F);
      send_item(16'hFFC0, 16'hFFC0);
      send_item(16'h8000, 16'h8000);
      send_item(16'h7FFF, 16'h7FFF);
      send_item(16'h5555, 16'hAAAA);
      send_item(16'hAAAA, 16'h5555);
      send_item(16'h6A80, 16'h5E00);
      drain();

      // count above range
      load_coefs('{a0: 16'sh7FFF, default: '0});
      send_item(16'h0000, 16'h0000);
      send_item(16'hFFFF, 16'hFFFF);
      drain();

      // count below range
      load_coefs('{a0: 16'sh8000, default: '0});
      send_item(16'h0000, 16'h0000);
      send_item(16'hFFFF, 16'hFFFF);
      drain();

      load_coefs('{default: 16'sh7FFF});
      send_item(16'hFFFF, 16'hFFFF);
      send_item(16'h4040, 16'h7FC0);
      drain();

      load_coefs('{default: 16'sh8000});
      send_item(16'hFFFF, 16'hFFFF);
      send_item(16'h4040, 16'h7FC0);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 3 || ph == 7) begin
            cs = coef_type'({$urandom, $urandom, $urandom});
         end else begin
            cs.a0  = CoefWidth'(16078 + int'($urandom_range(0, 2047)) - 1024);
            cs.b1  = CoefWidth'(-19463 + int'($urandom_range(0, 2047)) - 1024);
            cs.b2  = CoefWidth'(-15081 + int'($urandom_range(0, 2047)) - 1024);
            cs.c12 = CoefWidth'(13256 + int'($urandom_range(0, 2047)) - 1024);
            cs.c11 = CoefWidth'(int'($urandom_range(0, 4095)) - 2048);
            cs.c22 = CoefWidth'(int'($urandom_range(0, 4095)) - 2048);
         end
         load_coefs(cs);
         case (ph % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 64; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 64; end
            default: begin idle_pct = 37; stall_pct = 37; end
         endcase
         if (ph == 4)
            hold_go = 1'b1;
         for (int i = 0; i < 200; i++) begin
            if (ph == 6 && i == 100)
               drain();
            send_item(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
         end
         drain();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
